[rtl/core/cds_pkg.sv]
// Shared types and constants for the calendar date stepper.
`default_nettype none

package cds_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 14;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartDay   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgStartMonth = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgStartYear  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgEndYear    = 8'd3;

  // Reset values
  localparam logic [DayW-1:0]   RstStartDay   = 5'd6;
  localparam logic [MonthW-1:0] RstStartMonth = 4'd1;
  localparam logic [YearW-1:0]  RstStartYear  = 14'd1901;
  localparam logic [YearW-1:0]  RstEndYear    = 14'd2000;

  localparam logic [DayW-1:0]   MaxStep  = 5'd27;
  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;
  localparam logic [MonthW:0]   LastMonth = 5'd12;

  typedef struct packed {
    logic            restart;
    logic [DayW-1:0] step_days;
  } cds_in_t;

  typedef struct packed {
    logic [DayW-1:0]   cur_day;
    logic [MonthW-1:0] cur_month;
    logic [YearW-1:0]  cur_year;
    logic [CountW-1:0] first_count;
    logic              past_end;
  } cds_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cds_cfg_t;

endpackage

`default_nettype wire

[rtl/core/cds_if.sv]
// Valid/ready channel interfaces for the calendar date stepper.
`default_nettype none

interface cds_in_if;
  import cds_pkg::*;
  logic    valid;
  logic    ready;
  cds_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cds_out_if;
  import cds_pkg::*;
  logic     valid;
  logic     ready;
  cds_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cds_cfg_if;
  import cds_pkg::*;
  logic     valid;
  logic     ready;
  cds_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/calendar_date_stepper.sv]
// Gregorian date stepper: holds day/month/year and a first-of-month count.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle; input stalls only while the result
//   register is full and the sink holds ready low.
// Reset: date goes to 1901-01-06, count to 0, config to its defaults,
//   result register empty.
`default_nettype none

module calendar_date_stepper (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cds_in_if.sink     in_chan_i,
  cds_cfg_if.sink    cfg_chan_i,
  cds_out_if.source  out_chan_o
);
  import cds_pkg::*;

  // Divisibility by 25 on a 14-bit year: multiply by the inverse of 25
  // mod 2^14 and check the product lands in the low band.
  localparam logic [YearW-1:0] Inv25   = 14'd7209;
  localparam logic [YearW-1:0] Band25  = 14'd655;

  // ---------------------------------------------------------------
  // Configuration registers (always ready, unknown indexes dropped)
  // ---------------------------------------------------------------
  logic [DayW-1:0]   start_day_q;
  logic [MonthW-1:0] start_month_q;
  logic [YearW-1:0]  start_year_q;
  logic [YearW-1:0]  end_year_q;

  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_day_q   <= RstStartDay;
      start_month_q <= RstStartMonth;
      start_year_q  <= RstStartYear;
      end_year_q    <= RstEndYear;
    end else if (cfg_chan_i.valid) begin
      case (cfg_chan_i.data.index)
        CfgStartDay:   start_day_q   <= cfg_chan_i.data.value[DayW-1:0];
        CfgStartMonth: start_month_q <= cfg_chan_i.data.value[MonthW-1:0];
        CfgStartYear:  start_year_q  <= cfg_chan_i.data.value[YearW-1:0];
        CfgEndYear:    end_year_q    <= cfg_chan_i.data.value[YearW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake: the result register frees up in the same cycle it
  // is drained, so back-to-back requests flow without bubbles.
  // ---------------------------------------------------------------
  logic     out_valid_q;
  cds_out_t out_q;
  logic     in_fire;

  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;

  // ---------------------------------------------------------------
  // Date state
  // ---------------------------------------------------------------
  logic [DayW-1:0]   day_q,   day_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [YearW-1:0]  year_q,  year_d;
  logic [CountW-1:0] count_q, count_d;

  // Leap test on the held year
  logic [YearW-1:0] year_x_inv;
  logic             div4, div16, div25, leap;

  assign year_x_inv = year_q * Inv25;     // mod 2^14 by truncation
  assign div4  = (year_q[1:0] == 2'b00);
  assign div16 = (year_q[3:0] == 4'b0000);
  assign div25 = (year_x_inv <= Band25);
  // div by 100 = div4 & div25; div by 400 = div16 & div25
  assign leap  = div25 ? div16 : div4;

  // Month length; anything outside the short months counts as 31
  logic [DayW-1:0] month_len;

  always_comb begin
    if (month_q == 4'd2) begin
      month_len = leap ? 5'd29 : 5'd28;
    end else if (month_q inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      month_len = 5'd30;
    end else begin
      month_len = 5'd31;
    end
  end

  // Day step and month rollover
  logic [DayW-1:0] step_sat;
  logic [DayW:0]   day_sum;
  logic            day_wrap;
  logic [MonthW:0] month_nx;
  logic            year_wrap;
  logic [DayW:0]   day_wrapped;

  assign step_sat    = (in_chan_i.data.step_days > MaxStep) ? MaxStep
                                                            : in_chan_i.data.step_days;
  assign day_sum     = {1'b0, day_q} + {1'b0, step_sat};
  assign day_wrap    = day_sum > {1'b0, month_len};
  assign day_wrapped = day_sum - {1'b0, month_len};
  assign month_nx    = {1'b0, month_q} + {{MonthW{1'b0}}, day_wrap};
  // Held months 13..15 roll over too, even without a day wrap
  assign year_wrap   = month_nx > LastMonth;

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    count_d = count_q;
    if (in_chan_i.data.restart) begin
      day_d   = start_day_q;
      month_d = start_month_q;
      year_d  = (start_year_q > YearMax) ? YearMax : start_year_q;
      count_d = '0;
    end else begin
      // Count the date before it moves
      if (day_q == 5'd1 && year_q <= end_year_q && count_q != CountMax) begin
        count_d = count_q + 16'd1;
      end
      day_d = day_wrap ? day_wrapped[DayW-1:0] : day_sum[DayW-1:0];
      if (year_wrap) begin
        month_d = 4'd1;
        year_d  = (year_q < YearMax) ? year_q + 14'd1 : YearMax;
      end else begin
        month_d = month_nx[MonthW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= RstStartDay;
      month_q <= RstStartMonth;
      year_q  <= RstStartYear;
      count_q <= '0;
    end else if (in_fire) begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.cur_day     <= day_d;
      out_q.cur_month   <= month_d;
      out_q.cur_year    <= year_d;
      out_q.first_count <= count_d;
      out_q.past_end    <= year_d > end_year_q;
    end
  end

  assign out_chan_o.valid = out_valid_q;
  assign out_chan_o.data  = out_q;

endmodule

`default_nettype wire
